// File: rtl/assert_macros.svh
// Assertion macros used by the checker file rtl/ovn_check.sv.
// Holds no logic, only property wrappers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: rtl/ovn_pkg.sv
// Package for the octave value noise block: widths, reset values, codes.
// No dependencies.
`default_nettype none
package ovn_pkg;
  localparam int unsigned MaxOctaves = 16;
  localparam logic [1:0] RegSeed = 2'd0;
  localparam logic [1:0] RegPers = 2'd1;
  localparam logic [1:0] RegOct  = 2'd2;
  localparam logic [30:0] SeedReset = 31'd1;
  localparam logic [16:0] PersReset = 17'd32768;
  localparam logic [4:0]  OctReset  = 5'd4;
  localparam logic [31:0] HashK1 = 32'd15731;
  localparam logic [31:0] HashK2 = 32'd789221;
  localparam logic [31:0] HashK3 = 32'd1376312589;
endpackage
`default_nettype wire

// File: rtl/ovn_mul.sv
// Shared 32x32 multiplier with registered low-word product.
// Used by the top level sequencer; no package dependency.
`default_nettype none
module ovn_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] p_o
);
  logic [31:0] p_q;
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end
  assign p_o = p_q;
endmodule
`default_nettype wire

// File: rtl/octave_value_noise_2d.sv
// Top level of the octave value noise block: config, sequencer, accumulator.
// Depends on ovn_pkg and ovn_mul.
// Each octave hashes the nine neighbours of its point in the states PT, M1 to M6 and ACC, then
// weights the sum in AMP and AMP2; done_o is high in S_FIN, after S_OUT ends the last octave.
// A new start is taken only when idle, after the last result; the shared 32x32 multiplier sets this.
// Reset: seed 1, persistence 0.5, four octaves; idle. The receiver cannot stall results.
`default_nettype none
module octave_value_noise_2d #(
  parameter int unsigned MAX_OCTAVES = ovn_pkg::MaxOctaves
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] x_coord_i,
  input  wire logic signed [31:0] y_coord_i,
  output logic                    done_o,
  output logic signed [31:0]      height_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  localparam int unsigned OW = $clog2(MAX_OCTAVES + 1);
  localparam logic [OW-1:0] MaxOct = OW'(MAX_OCTAVES);

  localparam logic [3:0] S_IDLE = 4'd0, S_OCT = 4'd1, S_PT = 4'd2, S_M1 = 4'd3,
    S_M2 = 4'd4, S_M3 = 4'd5, S_M4 = 4'd6, S_M5 = 4'd7, S_M6 = 4'd8,
    S_ACC = 4'd9, S_AMP = 4'd10, S_AMP2 = 4'd11, S_OUT = 4'd12, S_FIN = 4'd13;

  logic [30:0] seed_q, seedc_q;
  logic [16:0] pers_q;
  logic [4:0]  oct_q;
  logic [3:0]  st_q, st_d;
  logic [31:0] px_q, py_q, n_q, t_q;
  logic [30:0] a_q;
  logic [OW-1:0] cnt_q, lim_q;
  logic [1:0]  dx_q, dy_q;
  logic [16:0] amp_q, persc_q, amp_d;
  logic signed [38:0] sm_q;
  logic signed [63:0] tot_q;
  logic signed [31:0] h_q;
  logic done_q;
  logic cfg_we;
  logic [31:0] ma, mb, mp;
  logic [31:0] qx, qy, n0, nb;
  logic [30:0] hv;
  logic signed [31:0] nz;
  logic signed [38:0] wt;
  logic signed [56:0] wamp;
  logic signed [63:0] q;

  ovn_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(mp));

  assign busy = (st_q != S_IDLE);
  assign cfg_ready_o = (st_q == S_IDLE);
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  assign done_o = done_q;
  assign height_o = h_q;

  // Neighbor offsets dx, dy run over 0..2 and stand for -1, 0, +1.
  always_comb begin
    qx = px_q + 32'(dx_q) - 32'd1;
    qy = py_q + 32'(dy_q) - 32'd1;
    n0 = qx + ((qy << 6) - (qy << 3) + qy);
    nb = (n0 << 13) ^ n0;
    hv = mp[30:0] + a_q;
    nz = 32'sh4000_0000 - $signed({1'b0, hv});
    unique case ({dx_q == 2'd1, dy_q == 2'd1})
      2'b11:   wt = 39'(nz) <<< 2;
      2'b10,
      2'b01:   wt = 39'(nz) <<< 1;
      default: wt = 39'(nz);
    endcase
    wamp = sm_q * $signed({1'b0, amp_q});
    // Only one times one overflows the low product word; it leaves the amplitude as is.
    amp_d = (amp_q[16] && persc_q[16]) ? amp_q : {1'b0, mp[31:16]};
    q = tot_q >>> 26;
  end

  always_comb begin
    ma = n_q;
    mb = n_q;
    unique case (st_q)
      S_M2:  begin ma = mp; mb = ovn_pkg::HashK1; end
      S_M3:  begin ma = mp; mb = {1'b0, seedc_q}; end
      S_M4:  begin ma = {1'b0, seedc_q}; mb = ovn_pkg::HashK2; end
      S_M5:  begin ma = {1'b0, seedc_q}; mb = ovn_pkg::HashK3; end
      S_M6:  begin ma = n_q; mb = t_q; end
      S_AMP: begin ma = {15'd0, amp_q}; mb = {15'd0, persc_q}; end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (start) st_d = S_OCT;
      S_OCT:  st_d = (cnt_q == lim_q) ? S_OUT : S_PT;
      S_PT:   st_d = S_M1;
      S_M1:   st_d = S_M2;
      S_M2:   st_d = S_M3;
      S_M3:   st_d = S_M4;
      S_M4:   st_d = S_M5;
      S_M5:   st_d = S_M6;
      S_M6:   st_d = S_ACC;
      S_ACC:  st_d = (dx_q == 2'd2 && dy_q == 2'd2) ? S_AMP : S_PT;
      S_AMP:  st_d = S_AMP2;
      S_AMP2: st_d = S_OCT;
      S_OUT:  st_d = S_FIN;
      S_FIN:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      done_q  <= 1'b0;
      seed_q  <= ovn_pkg::SeedReset;
      pers_q  <= ovn_pkg::PersReset;
      oct_q   <= ovn_pkg::OctReset;
      seedc_q <= '0;
      px_q    <= '0;
      py_q    <= '0;
      n_q     <= '0;
      t_q     <= '0;
      a_q     <= '0;
      cnt_q   <= '0;
      lim_q   <= '0;
      dx_q    <= '0;
      dy_q    <= '0;
      amp_q   <= '0;
      persc_q <= '0;
      sm_q    <= '0;
      tot_q   <= '0;
      h_q     <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == S_OUT);
      if (cfg_we) begin
        unique case (cfg_index_i)
          ovn_pkg::RegSeed: seed_q <= cfg_data_i[30:0];
          ovn_pkg::RegPers: pers_q <= cfg_data_i[16:0];
          ovn_pkg::RegOct:  oct_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      // Hash steps: t holds n*n*K1*s and then adds K2*s; a holds K3*s for the last sum.
      unique case (st_q)
        S_IDLE: begin
          px_q <= x_coord_i;
          py_q <= y_coord_i;
          seedc_q <= seed_q;
          cnt_q <= '0;
          lim_q <= (32'(oct_q) > 32'(MaxOct)) ? MaxOct : OW'(oct_q);
          persc_q <= (pers_q > 17'd65536) ? 17'd65536 : pers_q;
          amp_q <= 17'd65536;
          tot_q <= '0;
          sm_q <= '0;
          dx_q <= '0;
          dy_q <= '0;
        end
        S_OCT: begin
          dx_q <= '0;
          dy_q <= '0;
          sm_q <= '0;
        end
        S_PT:  n_q <= nb;
        S_M4:  t_q <= mp;
        S_M5:  t_q <= t_q + mp;
        S_M6:  a_q <= mp[30:0];
        S_ACC: begin
          sm_q <= sm_q + wt;
          if (dx_q == 2'd2) begin
            dx_q <= '0;
            dy_q <= dy_q + 2'd1;
          end else begin
            dx_q <= dx_q + 2'd1;
          end
        end
        S_AMP: tot_q <= tot_q + 64'(wamp);
        S_AMP2: begin
          amp_q <= amp_d;
          cnt_q <= cnt_q + OW'(1);
          px_q <= px_q << 1;
          py_q <= py_q << 1;
        end
        S_OUT: begin
          if (q > 64'sh7fff_ffff) h_q <= 32'sh7fff_ffff;
          else if (q < -64'sh8000_0000) h_q <= 32'sh8000_0000;
          else h_q <= q[31:0];
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/ovn_check.sv
// Port-level checker for octave_value_noise_2d, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ovn_check (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);
  `ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_NEXT(a_idle_after_done, clk_i, rst_ni, done_o, !busy)
  `ASSERT_IMPL(a_done_while_busy, clk_i, rst_ni, done_o, busy)
  `ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
endmodule
bind octave_value_noise_2d ovn_check u_ovn_check (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o));
`default_nettype wire

// File: dv/octave_value_noise_2d_tb.sv
// Self-checking testbench for the octave value noise block, top module last.
// Depends on ovn_pkg and the octave_value_noise_2d RTL; predicts each height itself.
`default_nettype none
module octave_value_noise_2d_tb;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  localparam int unsigned IdleLimit = 40000;
  localparam logic [1:0] RegUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] x_coord_i = '0;
  logic signed [31:0] y_coord_i = '0;
  logic done_o;
  logic signed [31:0] height_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Configuration as the block should hold it.
  logic [30:0] seed_m = ovn_pkg::SeedReset;
  logic [16:0] pers_m = ovn_pkg::PersReset;
  logic [4:0]  oct_m  = ovn_pkg::OctReset;

  point_t pending_q[$];
  logic signed [31:0] height_exp_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned errors = 0;
  int unsigned n_points = 0;
  int unsigned n_heights = 0;
  int unsigned n_writes = 0;
  int unsigned quiet_cycles = 0;
  logic cfg_hit;

  octave_value_noise_2d dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .x_coord_i(x_coord_i), .y_coord_i(y_coord_i),
    .done_o(done_o), .height_o(height_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint lattice_hash(logic [31:0] px, logic [31:0] py);
    logic [31:0] n, a, b, s;
    s = {1'b0, seed_m};
    n = px + py * 32'd57;
    n = (n << 13) ^ n;
    a = n * n;
    a = a * ovn_pkg::HashK1;
    a = a * s;
    a = a + ovn_pkg::HashK2 * s;
    b = n * a;
    b = (b + ovn_pkg::HashK3 * s) & 32'h7fff_ffff;
    return 64'sd1073741824 - longint'({32'd0, b});
  endfunction

  function automatic longint smoothed(logic [31:0] px, logic [31:0] py);
    logic [31:0] xm, xp, ym, yp;
    longint c, sd;
    xm = px - 1; xp = px + 1; ym = py - 1; yp = py + 1;
    c = lattice_hash(xm, ym) + lattice_hash(xp, ym) + lattice_hash(xm, yp)
      + lattice_hash(xp, yp);
    sd = lattice_hash(xm, py) + lattice_hash(xp, py) + lattice_hash(px, ym)
       + lattice_hash(px, yp);
    return c + 2 * sd + 4 * lattice_hash(px, py);
  endfunction

  function automatic logic signed [31:0] predict_height(point_t p);
    int unsigned count, pers;
    longint amp, total, q;
    logic [31:0] sx, sy;
    count = (oct_m > ovn_pkg::MaxOctaves) ? ovn_pkg::MaxOctaves : oct_m;
    pers = (pers_m > 17'd65536) ? 65536 : pers_m;
    amp = 65536;
    total = 0;
    for (int unsigned i = 0; i < count; i++) begin
      sx = p.x << i;
      sy = p.y << i;
      total += smoothed(sx, sy) * amp;
      amp = (amp * pers) >>> 16;
    end
    q = total >>> 26;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // Driver: holds start until the block takes the point, then picks the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        height_exp_q.push_back(predict_height('{x: x_coord_i, y: y_coord_i}));
        n_points++;
      end
      if (!(start && busy)) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          point_t p;
          p = pending_q.pop_front();
          x_coord_i <= p.x;
          y_coord_i <= p.y;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (height_exp_q.size() == 0) begin
        $display("%0t: unexpected height, expected none, actual %0d", $time, height_o);
        errors++;
      end else begin
        logic signed [31:0] want;
        want = height_exp_q.pop_front();
        if (height_o !== want) begin
          $display("%0t: height mismatch, expected %0d, actual %0d", $time, want, height_o);
          errors++;
        end
        n_heights++;
      end
    end
  end

  // Watchdog on cycles in which no transaction of any kind happens.
  always @(posedge clk_i) begin
    cfg_hit = cfg_valid_i && cfg_ready_o;
    if (!rst_ni || (start && !busy) || done_o || cfg_hit) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || start || busy || height_exp_q.size() != 0);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      ovn_pkg::RegSeed: seed_m = data[30:0];
      ovn_pkg::RegPers: pers_m = data[16:0];
      ovn_pkg::RegOct:  oct_m  = data[4:0];
      default: ;
    endcase
    n_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [31:0] seed, logic [31:0] pers, logic [31:0] oct);
    wait_idle();
    write_reg(ovn_pkg::RegSeed, seed);
    write_reg(ovn_pkg::RegPers, pers);
    write_reg(ovn_pkg::RegOct, oct);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(64) - 32;
      1: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      pending_q.push_back('{x: rand_coord(), y: rand_coord()});
  endtask

  initial begin
    logic signed [31:0] edge_vals[5];
    logic [31:0] pers, oct;
    edge_vals = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration, corner coordinates including wrap at both ends.
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j += 2)
        pending_q.push_back('{x: edge_vals[i], y: edge_vals[j]});
    // Zero octaves with the largest seed and no persistence.
    configure(32'hffff_ffff, 0, 0);
    queue_random(3);
    // Octave count and persistence beyond their limits are clamped.
    configure($urandom, 32'h0001_ffff, 31);
    pending_q.push_back('{x: 32'sh7fff_ffff, y: 32'sh8000_0000});
    pending_q.push_back('{x: $urandom, y: $urandom});
    configure($urandom, 65536, 16);
    queue_random(2);
    // A write to an unused index must leave the configuration alone.
    configure(0, 32768, 3);
    wait_idle();
    write_reg(RegUnused, $urandom);
    queue_random(3);

    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(4))
        0: pers = 0;
        1: pers = 65536;
        2: pers = $urandom;
        default: pers = $urandom_range(65535);
      endcase
      oct = (ph == 5) ? 16 : $urandom_range(4, 1) | ($urandom & 32'hffff_ffe0);
      configure($urandom, pers, oct);
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 2) ? 46 : (ph % 4 == 3) ? 32 : 0;
      queue_random((ph == 5) ? 6 : 64);
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d points, %0d heights and %0d register writes across",
             n_points, n_heights, n_writes);
    $display("clamped, zero and random octave settings with sender idling.");
    if (errors == 0 && height_exp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: octave_value_noise_2d.f
+incdir+rtl
rtl/ovn_pkg.sv
rtl/ovn_mul.sv
rtl/octave_value_noise_2d.sv
rtl/ovn_check.sv
dv/octave_value_noise_2d_tb.sv
